/* src/aljcpu_pkg.sv */
// shared types, opcodes and datapath select codes for the accumulator cpu step block
package aljcpu_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int CFG_AW        = 3;

  localparam logic [15:0] PC_RESET   = 16'hFFFA;
  localparam logic [15:0] STACK_BASE = 16'h0100;

  // item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EXEC  = 1'b1;

  // opcodes
  localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
  localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
  localparam logic [7:0] OP_LDA_INDX = 8'hA1;
  localparam logic [7:0] OP_LDA_INDY = 8'hB1;
  localparam logic [7:0] OP_JSR      = 8'h20;
  localparam logic [7:0] OP_RTS      = 8'h60;

  // memory address source
  typedef logic [3:0] addr_sel_t;
  localparam addr_sel_t ADDR_PC   = 4'd0;
  localparam addr_sel_t ADDR_ZP   = 4'd1;
  localparam addr_sel_t ADDR_PTR  = 4'd2;
  localparam addr_sel_t ADDR_WORD = 4'd3;
  localparam addr_sel_t ADDR_STK  = 4'd4;
  localparam addr_sel_t ADDR_STK1 = 4'd5;
  localparam addr_sel_t ADDR_RET  = 4'd6;
  localparam addr_sel_t ADDR_RET1 = 4'd7;
  localparam addr_sel_t ADDR_IN   = 4'd8;
  localparam addr_sel_t ADDR_CLR  = 4'd9;

  // index register added to an address
  typedef logic [1:0] idx_sel_t;
  localparam idx_sel_t IDX_NONE = 2'd0;
  localparam idx_sel_t IDX_X    = 2'd1;
  localparam idx_sel_t IDX_Y    = 2'd2;

  // memory write data source
  typedef logic [1:0] wd_sel_t;
  localparam wd_sel_t WD_IN   = 2'd0;
  localparam wd_sel_t WD_PCL  = 2'd1;
  localparam wd_sel_t WD_PCH  = 2'd2;
  localparam wd_sel_t WD_ZERO = 2'd3;

  typedef struct packed {
    addr_sel_t addr_sel;
    idx_sel_t  idx_sel;
    wd_sel_t   wd_sel;
    logic      we;
    logic      in_ld;
    logic      clr_step;
    logic      op_ld;
    logic      lo_ld;
    logic      hi_ld;
    logic      ptr_ld;
    logic      pc_inc;
    logic      pc_jump;
    logic      pc_ret;
    logic      sp_add;
    logic      sp_sub;
    logic      acc_ld;
    logic      fault_set;
    logic      fault_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] op;
    logic       clr_last;
  } dp_status_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic        zero_flag;
    logic        negative_flag;
    logic [15:0] pc;
    logic [7:0]  sp;
    logic        fault;
  } arch_t;

endpackage

/* src/aljcpu_if.sv */
// request and result channel interfaces
interface aljcpu_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] addr;
  logic [7:0]  data;

  modport source (output valid, cmd, addr, data, input ready);
  modport sink (input valid, cmd, addr, data, output ready);
endinterface

interface aljcpu_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc;
  logic        zero_flag;
  logic        negative_flag;
  logic [15:0] pc;
  logic [7:0]  sp;
  logic        fault;

  modport source (output valid, acc, zero_flag, negative_flag, pc, sp, fault, input ready);
  modport sink (input valid, acc, zero_flag, negative_flag, pc, sp, fault, output ready);
endinterface

/* src/aljcpu_ram.sv */
// generic single-port ram with registered read
module aljcpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/aljcpu_dp.sv */
// datapath: architectural registers, address and data muxes, memory
module aljcpu_dp #(
  parameter int MEM_BYTES = aljcpu_pkg::MEM_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  aljcpu_pkg::dp_cmd_t    cmd,
  input  logic [7:0]             index_x,
  input  logic [7:0]             index_y,
  input  logic [15:0]            in_addr,
  input  logic [7:0]             in_data,
  output aljcpu_pkg::dp_status_t status,
  output aljcpu_pkg::arch_t      arch
);
  import aljcpu_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  logic [15:0]   pc;
  logic [7:0]    sp;
  logic [7:0]    acc;
  logic          zf;
  logic          nf;
  logic          fault;
  logic [7:0]    op;
  logic [7:0]    lo;
  logic [7:0]    hi;
  logic [7:0]    ptr;
  logic [15:0]   in_addr_q;
  logic [7:0]    in_data_q;
  logic [AW-1:0] clr_cnt;

  logic [7:0]    rdata;
  logic [7:0]    idx;
  logic [7:0]    zp_sum;
  logic [7:0]    ptr_inc;
  logic [15:0]   word_sum;
  logic [15:0]   stk_base;
  logic [15:0]   addr_mux;
  logic [7:0]    wdata;

  always_comb begin
    case (cmd.idx_sel)
      IDX_X:   idx = index_x;
      IDX_Y:   idx = index_y;
      default: idx = 8'h00;
    endcase
  end

  assign zp_sum   = rdata + idx;
  assign ptr_inc  = ptr + 8'd1;
  assign word_sum = {rdata, lo} + {8'h00, idx};
  assign stk_base = STACK_BASE + {8'h00, sp};

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_PC:   addr_mux = pc;
      ADDR_ZP:   addr_mux = {8'h00, zp_sum};
      ADDR_PTR:  addr_mux = {8'h00, ptr_inc};
      ADDR_WORD: addr_mux = word_sum;
      ADDR_STK:  addr_mux = stk_base;
      ADDR_STK1: addr_mux = stk_base + 16'd1;
      ADDR_RET:  addr_mux = stk_base - 16'd2;
      ADDR_RET1: addr_mux = stk_base - 16'd1;
      ADDR_IN:   addr_mux = in_addr_q;
      ADDR_CLR:  addr_mux = 16'(clr_cnt);
      default:   addr_mux = pc;
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_IN:   wdata = in_data_q;
      WD_PCL:  wdata = pc[7:0];
      WD_PCH:  wdata = pc[15:8];
      WD_ZERO: wdata = 8'h00;
      default: wdata = 8'h00;
    endcase
  end

  aljcpu_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .addr  (addr_mux[AW-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= PC_RESET;
      sp      <= 8'h00;
      acc     <= 8'h00;
      zf      <= 1'b0;
      nf      <= 1'b0;
      fault   <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cmd.pc_inc) begin
        pc <= pc + 16'd1;
      end else if (cmd.pc_jump) begin
        pc <= {hi, lo};
      end else if (cmd.pc_ret) begin
        pc <= {rdata, lo};
      end
      if (cmd.sp_add) begin
        sp <= sp + 8'd2;
      end else if (cmd.sp_sub) begin
        sp <= sp - 8'd2;
      end
      if (cmd.acc_ld) begin
        acc <= rdata;
        zf  <= (rdata == 8'h00);
        nf  <= rdata[7];
      end
      if (cmd.fault_clr) begin
        fault <= 1'b0;
      end else if (cmd.fault_set) begin
        fault <= 1'b1;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // operand and pointer scratch registers
  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      in_addr_q <= in_addr;
      in_data_q <= in_data;
    end
    if (cmd.op_ld) begin
      op <= rdata;
    end
    if (cmd.lo_ld) begin
      lo <= rdata;
    end
    if (cmd.hi_ld) begin
      hi <= rdata;
    end
    if (cmd.ptr_ld) begin
      ptr <= zp_sum;
    end
  end

  assign status.rdata    = rdata;
  assign status.op       = op;
  assign status.clr_last = (clr_cnt == AW'(MEM_BYTES - 1));

  assign arch.acc           = acc;
  assign arch.zero_flag     = zf;
  assign arch.negative_flag = nf;
  assign arch.pc            = pc;
  assign arch.sp            = sp;
  assign arch.fault         = fault;

endmodule

/* src/aljcpu_ctrl.sv */
// controller: sequences memory accesses for clearing, writes and instructions
module aljcpu_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  input  logic                   out_free,
  input  aljcpu_pkg::dp_status_t status,
  output logic                   in_ready,
  output logic                   res_ld,
  output aljcpu_pkg::dp_cmd_t    cmd
);
  import aljcpu_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WRITE  = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_DECODE = 4'd4;
  localparam logic [3:0] S_OPER1  = 4'd5;
  localparam logic [3:0] S_OPER2  = 4'd6;
  localparam logic [3:0] S_PTR1   = 4'd7;
  localparam logic [3:0] S_PTR2   = 4'd8;
  localparam logic [3:0] S_LOAD   = 4'd9;
  localparam logic [3:0] S_JSR2   = 4'd10;
  localparam logic [3:0] S_RET1   = 4'd11;
  localparam logic [3:0] S_RET2   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    res_ld     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = ADDR_CLR;
        cmd.wd_sel   = WD_ZERO;
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_ld     = 1'b1;
          cmd.fault_clr = 1'b1;
          state_next    = (in_cmd == CMD_WRITE) ? S_WRITE : S_FETCH;
        end
      end
      S_WRITE: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = ADDR_IN;
        cmd.wd_sel   = WD_IN;
        state_next   = S_DONE;
      end
      S_FETCH: begin
        cmd.addr_sel = ADDR_PC;
        cmd.pc_inc   = 1'b1;
        state_next   = S_DECODE;
      end
      S_DECODE: begin
        cmd.op_ld = 1'b1;
        unique case (status.rdata) inside
          OP_RTS: begin
            cmd.addr_sel = ADDR_RET;
            state_next   = S_RET1;
          end
          OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ZPX, OP_LDA_ABS, OP_LDA_ABSX,
          OP_LDA_ABSY, OP_LDA_INDX, OP_LDA_INDY, OP_JSR: begin
            cmd.addr_sel = ADDR_PC;
            cmd.pc_inc   = 1'b1;
            state_next   = S_OPER1;
          end
          default: begin
            cmd.fault_set = 1'b1;
            state_next    = S_DONE;
          end
        endcase
      end
      S_OPER1: begin
        unique case (status.op) inside
          OP_LDA_IMM: begin
            cmd.acc_ld = 1'b1;
            state_next = S_DONE;
          end
          OP_LDA_ZP: begin
            cmd.addr_sel = ADDR_ZP;
            state_next   = S_LOAD;
          end
          OP_LDA_ZPX: begin
            cmd.addr_sel = ADDR_ZP;
            cmd.idx_sel  = IDX_X;
            state_next   = S_LOAD;
          end
          OP_LDA_INDX: begin
            cmd.addr_sel = ADDR_ZP;
            cmd.idx_sel  = IDX_X;
            cmd.ptr_ld   = 1'b1;
            state_next   = S_PTR1;
          end
          OP_LDA_INDY: begin
            cmd.addr_sel = ADDR_ZP;
            cmd.ptr_ld   = 1'b1;
            state_next   = S_PTR1;
          end
          OP_LDA_ABS, OP_LDA_ABSX, OP_LDA_ABSY, OP_JSR: begin
            cmd.lo_ld    = 1'b1;
            cmd.addr_sel = ADDR_PC;
            cmd.pc_inc   = 1'b1;
            state_next   = S_OPER2;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_OPER2: begin
        unique case (status.op) inside
          OP_LDA_ABS: begin
            cmd.addr_sel = ADDR_WORD;
            state_next   = S_LOAD;
          end
          OP_LDA_ABSX: begin
            cmd.addr_sel = ADDR_WORD;
            cmd.idx_sel  = IDX_X;
            state_next   = S_LOAD;
          end
          OP_LDA_ABSY: begin
            cmd.addr_sel = ADDR_WORD;
            cmd.idx_sel  = IDX_Y;
            state_next   = S_LOAD;
          end
          OP_JSR: begin
            // pc already points past the operands: push its low byte
            cmd.hi_ld    = 1'b1;
            cmd.we       = 1'b1;
            cmd.addr_sel = ADDR_STK;
            cmd.wd_sel   = WD_PCL;
            state_next   = S_JSR2;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_PTR1: begin
        cmd.lo_ld    = 1'b1;
        cmd.addr_sel = ADDR_PTR;
        state_next   = S_PTR2;
      end
      S_PTR2: begin
        cmd.addr_sel = ADDR_WORD;
        cmd.idx_sel  = (status.op == OP_LDA_INDY) ? IDX_Y : IDX_NONE;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.acc_ld = 1'b1;
        state_next = S_DONE;
      end
      S_JSR2: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = ADDR_STK1;
        cmd.wd_sel   = WD_PCH;
        cmd.pc_jump  = 1'b1;
        cmd.sp_add   = 1'b1;
        state_next   = S_DONE;
      end
      S_RET1: begin
        cmd.lo_ld    = 1'b1;
        cmd.addr_sel = ADDR_RET1;
        state_next   = S_RET2;
      end
      S_RET2: begin
        cmd.pc_ret = 1'b1;
        cmd.sp_sub = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_ld     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/accumulator_load_jsr_cpu_step.sv */
// top level of the accumulator load / subroutine cpu step block
//
//   channel   dir   handshake           payload
//   req       in    valid/ready         cmd, addr, data
//   rsp       out   valid/ready         acc, zero_flag, negative_flag, pc, sp, fault
//   apb       in    psel/penable/pwrite index_x at 0x0, index_y at 0x4
//
// after reset the memory is swept to zero, one byte a cycle, all MEM_BYTES bytes
//   (65536 at the default), while req.ready stays low; apb writes still land
// one item at a time through a single-port memory with registered read: a write
//   item stores its byte; an instruction reads its opcode, then its operand
//   bytes, any pointer bytes, and the loaded byte or the stack bytes in turn;
//   an unknown opcode sets fault; no new item is taken before the result is loaded
// the result sits in an output register; a stalled rsp holds the core in its
//   final state until the register frees up
module accumulator_load_jsr_cpu_step #(
  parameter int MEM_BYTES = aljcpu_pkg::MEM_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aljcpu_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  aljcpu_req_if.sink                    req,
  aljcpu_rsp_if.source                  rsp
);
  import aljcpu_pkg::*;

  // register select is the word index within the apb window
  localparam logic REG_SEL_X = 1'b0;
  localparam logic REG_SEL_Y = 1'b1;

  logic [7:0] index_x;
  logic [7:0] index_y;
  logic       cfg_wr;
  logic       reg_sel;

  dp_cmd_t    cmd;
  dp_status_t status;
  arch_t      arch;
  logic       res_ld;
  logic       out_free;
  logic       out_valid;
  arch_t      res;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_AW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      index_x <= 8'h00;
      index_y <= 8'h00;
    end else if (cfg_wr) begin
      if (reg_sel == REG_SEL_Y) begin
        index_y <= pwdata[7:0];
      end else begin
        index_x <= pwdata[7:0];
      end
    end
  end

  assign prdata = {24'h000000, (reg_sel == REG_SEL_Y) ? index_y : index_x};

  // controller and datapath
  aljcpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .out_free (out_free),
    .status   (status),
    .in_ready (req.ready),
    .res_ld   (res_ld),
    .cmd      (cmd)
  );

  aljcpu_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .index_x (index_x),
    .index_y (index_y),
    .in_addr (req.addr),
    .in_data (req.data),
    .status  (status),
    .arch    (arch)
  );

  // result register: free when empty or being taken this cycle
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ld) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      res <= arch;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.acc           = res.acc;
  assign rsp.zero_flag     = res.zero_flag;
  assign rsp.negative_flag = res.negative_flag;
  assign rsp.pc            = res.pc;
  assign rsp.sp            = res.sp;
  assign rsp.fault         = res.fault;

  // a new result never overwrites one that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    res_ld |-> (!out_valid || rsp.ready))
    else $error("result register overwritten while full");

  // the core leaves idle right after taking an item
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while one is in flight");

  // the stack pointer moves only by two in either direction
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (arch.sp == $past(arch.sp)
                     || arch.sp == 8'($past(arch.sp) + 8'd2)
                     || arch.sp == 8'($past(arch.sp) - 8'd2)))
    else $error("stack pointer moved by other than two");

  // a faulting instruction leaves the stack pointer alone
  assert property (@(posedge clk) disable iff (rst)
    (res_ld && arch.fault) |-> (arch.sp == $past(arch.sp)))
    else $error("stack pointer changed on an unknown opcode");

endmodule
